[hdl/nmea_rmc_field_extractor_assert.svh]
// Assertion macros shared by the sentence extractor modules
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define NRFE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define NRFE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed");

`endif

[hdl/nrfe_pkg.sv]
// Shared types, constants and the degree conversion for the sentence extractor
package nrfe_pkg;

  // Store sizes
  localparam int DIGIT_MAX  = 8;
  localparam int DATE_MAX   = 6;
  localparam int DIG_CNT_W  = $clog2(DIGIT_MAX + 1);
  localparam int DIG_IDX_W  = $clog2(DIGIT_MAX);
  localparam int DATE_CNT_W = $clog2(DATE_MAX + 1);
  localparam int DATE_IDX_W = $clog2(DATE_MAX);

  // Decoupling queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Tag register
  localparam int                 TAG_LEN   = 5;
  localparam logic [8*TAG_LEN-1:0] TAG_RESET = 40'h4750524D43;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  // Result event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_TAG     = 3'd1;
  localparam logic [2:0] EV_UTC     = 3'd2;
  localparam logic [2:0] EV_LAT     = 3'd3;
  localparam logic [2:0] EV_LAT_DIR = 3'd4;
  localparam logic [2:0] EV_LON     = 3'd5;
  localparam logic [2:0] EV_LON_DIR = 3'd6;
  localparam logic [2:0] EV_DATE    = 3'd7;

  // Output packing widths
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 4;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_UTC     = 7'b0000010,
    PH_LAT     = 7'b0000100,
    PH_LAT_DIR = 7'b0001000,
    PH_LON     = 7'b0010000,
    PH_LON_DIR = 7'b0100000,
    PH_DATE    = 7'b1000000
  } phase_e;

  // Classified byte as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       is_dollar;
    logic       is_comma;
    logic       is_dot;
    logic       is_digit;
    logic       is_ns;
    logic       is_ew;
  } rx_item_t;

  // Whole degrees from two or three leading digits, modulo 256
  function automatic logic [7:0] to_degrees(input logic [7:0] d0, input logic [7:0] d1,
                                            input logic [7:0] d2,
                                            input logic [DIG_CNT_W-1:0] len);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] v;
    a = d0 - CH_ZERO;
    b = d1 - CH_ZERO;
    c = d2 - CH_ZERO;
    v = '0;
    if (len == DIG_CNT_W'(4)) begin
      v = 8'(a * 8'd10 + b);
    end else if (len == DIG_CNT_W'(5)) begin
      v = 8'(a * 8'd100 + b * 8'd10 + c);
    end
    return v;
  endfunction

endpackage

[hdl/nrfe_front.sv]
// Front end: classify received bytes and queue them for the parser
`include "nmea_rmc_field_extractor_assert.svh"

module nrfe_front import nrfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       item_valid_o,
  input  logic       item_ready_i,
  output rx_item_t   item_o
);

  rx_item_t               cls;
  rx_item_t               queue_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]     cnt_q, cnt_d;
  logic                   push, pop;

  // Classify the incoming byte
  always_comb begin
    cls.data      = in_byte_i;
    cls.is_dollar = (in_byte_i == CH_DOLLAR);
    cls.is_comma  = (in_byte_i == CH_COMMA);
    cls.is_dot    = (in_byte_i == CH_DOT);
    cls.is_digit  = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE);
    cls.is_ns     = (in_byte_i == CH_N) || (in_byte_i == CH_S);
    cls.is_ew     = (in_byte_i == CH_E) || (in_byte_i == CH_W);
  end

  assign in_ready_o   = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified request
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

  `NRFE_ASSERT_NOW(a_q_no_overflow, cnt_q == Q_CNT_W'(Q_DEPTH), !push)
  `NRFE_ASSERT_NEXT(a_q_push_seen, push && !pop, cnt_q != '0)

endmodule

[hdl/nrfe_back.sv]
// Back end: sentence parser state, field stores and the result register
`include "nmea_rmc_field_extractor_assert.svh"

module nrfe_back import nrfe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [8*TAG_LEN-1:0]    cfg_wdata_i,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  rx_item_t                item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_DATA_W-1:0]   out_data_o,
  output logic [OUT_USER_W-1:0]   out_user_o
);

  logic [8*TAG_LEN-1:0]   tag_q;
  phase_e                 phase_q, phase_d;
  logic                   tag_active_q, tag_active_d;
  logic [7:0]             tag_chars_q [TAG_LEN];
  logic [7:0]             tag_chars_d [TAG_LEN];
  logic [2:0]             tag_count_q, tag_count_d;
  logic [7:0]             utc_q [6];
  logic [7:0]             utc_d [6];
  logic [2:0]             utc_count_q, utc_count_d;
  logic [7:0]             lat_dig_q [DIGIT_MAX];
  logic [7:0]             lat_dig_d [DIGIT_MAX];
  logic [DIG_CNT_W-1:0]   lat_count_q, lat_count_d;
  logic [7:0]             lon_dig_q [DIGIT_MAX];
  logic [7:0]             lon_dig_d [DIGIT_MAX];
  logic [DIG_CNT_W-1:0]   lon_count_q, lon_count_d;
  logic [7:0]             date_q [DATE_MAX];
  logic [7:0]             date_d [DATE_MAX];
  logic [DATE_CNT_W-1:0]  date_count_q, date_count_d;
  logic                   armed_q, armed_d;
  logic [7:0]             prev_q, prev_d;
  logic [7:0]             lat_deg_q, lat_deg_d;
  logic [DIG_CNT_W-1:0]   lat_len_q, lat_len_d;
  logic [7:0]             lat_hem_q, lat_hem_d;
  logic [7:0]             lon_deg_q, lon_deg_d;
  logic [DIG_CNT_W-1:0]   lon_len_q, lon_len_d;
  logic [7:0]             lon_hem_q, lon_hem_d;
  logic                   status_q, status_d;
  logic [2:0]             event_q, event_d;
  logic                   out_valid_q;
  logic                   fire;
  logic                   tag_ok;
  logic [7:0]             b;

  // Take a request when the result slot is free or being emptied
  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign b            = item_i.data;

  // Compare captured tag with the configured one
  always_comb begin
    tag_ok = 1'b1;
    for (int i = 0; i < TAG_LEN; i++) begin
      if (tag_chars_q[i] != tag_q[8*(TAG_LEN-1-i) +: 8]) begin
        tag_ok = 1'b0;
      end
    end
  end

  // Parse one character
  always_comb begin
    phase_d      = phase_q;
    tag_active_d = tag_active_q;
    tag_chars_d  = tag_chars_q;
    tag_count_d  = tag_count_q;
    utc_d        = utc_q;
    utc_count_d  = utc_count_q;
    lat_dig_d    = lat_dig_q;
    lat_count_d  = lat_count_q;
    lon_dig_d    = lon_dig_q;
    lon_count_d  = lon_count_q;
    date_d       = date_q;
    date_count_d = date_count_q;
    armed_d      = armed_q;
    prev_d       = prev_q;
    lat_deg_d    = lat_deg_q;
    lat_len_d    = lat_len_q;
    lat_hem_d    = lat_hem_q;
    lon_deg_d    = lon_deg_q;
    lon_len_d    = lon_len_q;
    lon_hem_d    = lon_hem_q;
    status_d     = 1'b0;
    event_d      = EV_NONE;

    if (item_i.is_dollar) begin
      tag_active_d = 1'b1;
      tag_count_d  = '0;
    end else if (tag_active_q) begin
      if (tag_count_q < 3'(TAG_LEN)) begin
        tag_chars_d[tag_count_q] = b;
        tag_count_d = tag_count_q + 3'd1;
      end else begin
        tag_active_d = 1'b0;
        tag_count_d  = '0;
        if (!tag_ok) begin
          status_d = 1'b1;
        end else begin
          event_d      = EV_TAG;
          phase_d      = PH_UTC;
          utc_count_d  = '0;
          lat_count_d  = '0;
          lon_count_d  = '0;
          date_count_d = '0;
          armed_d      = 1'b0;
          prev_d       = '0;
        end
      end
    end else begin
      case (phase_q)
        PH_UTC: begin
          if (!item_i.is_comma) begin
            if (utc_count_q < 3'd6) begin
              utc_d[utc_count_q] = b;
              utc_count_d = utc_count_q + 3'd1;
            end else begin
              utc_count_d = '0;
              phase_d     = PH_LAT;
              event_d     = EV_UTC;
            end
          end
        end
        PH_LAT: begin
          if (armed_q) begin
            if (item_i.is_dot && (lat_count_q != '0)) begin
              lat_len_d = lat_count_q;
              lat_deg_d = to_degrees(lat_dig_q[0], lat_dig_q[1], lat_dig_q[2], lat_count_q);
              phase_d   = PH_LAT_DIR;
              event_d   = EV_LAT;
            end else if (item_i.is_digit && (lat_count_q < DIG_CNT_W'(DIGIT_MAX))) begin
              lat_dig_d[lat_count_q[DIG_IDX_W-1:0]] = b;
              lat_count_d = lat_count_q + DIG_CNT_W'(1);
            end
          end else if (item_i.is_comma) begin
            armed_d = 1'b1;
          end
        end
        PH_LAT_DIR: begin
          if (item_i.is_ns) begin
            lat_hem_d = b;
            phase_d   = PH_LON;
            event_d   = EV_LAT_DIR;
          end
        end
        PH_LON: begin
          if (item_i.is_dot) begin
            lon_len_d = lon_count_q;
            lon_deg_d = to_degrees(lon_dig_q[0], lon_dig_q[1], lon_dig_q[2], lon_count_q);
            phase_d   = PH_LON_DIR;
            event_d   = EV_LON;
          end else if (item_i.is_digit && (lon_count_q < DIG_CNT_W'(DIGIT_MAX))) begin
            lon_dig_d[lon_count_q[DIG_IDX_W-1:0]] = b;
            lon_count_d = lon_count_q + DIG_CNT_W'(1);
          end
        end
        PH_LON_DIR: begin
          if (item_i.is_ew) begin
            lon_hem_d = b;
            phase_d   = PH_DATE;
            armed_d   = 1'b0;
            event_d   = EV_LON_DIR;
          end
        end
        PH_DATE: begin
          // Date opens after two adjacent commas and closes at the next comma
          if (item_i.is_comma && (prev_q == CH_COMMA)) begin
            armed_d = 1'b1;
          end else if (armed_q && !item_i.is_comma) begin
            if (date_count_q < DATE_CNT_W'(DATE_MAX)) begin
              date_d[date_count_q[DATE_IDX_W-1:0]] = b;
              date_count_d = date_count_q + DATE_CNT_W'(1);
            end
          end else if (armed_q && item_i.is_comma) begin
            phase_d = PH_IDLE;
            event_d = EV_DATE;
          end
          prev_d = b;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state, result status and stores with a defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q        <= TAG_RESET;
      phase_q      <= PH_IDLE;
      tag_active_q <= 1'b0;
      tag_count_q  <= '0;
      utc_count_q  <= '0;
      lat_count_q  <= '0;
      lon_count_q  <= '0;
      date_count_q <= '0;
      armed_q      <= 1'b0;
      prev_q       <= '0;
      lat_deg_q    <= '0;
      lat_len_q    <= '0;
      lat_hem_q    <= '0;
      lon_deg_q    <= '0;
      lon_len_q    <= '0;
      lon_hem_q    <= '0;
      status_q     <= 1'b0;
      event_q      <= EV_NONE;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        utc_q[i] <= '0;
      end
      for (int i = 0; i < DATE_MAX; i++) begin
        date_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        tag_q <= cfg_wdata_i;
      end
      if (fire) begin
        phase_q      <= phase_d;
        tag_active_q <= tag_active_d;
        tag_count_q  <= tag_count_d;
        utc_q        <= utc_d;
        utc_count_q  <= utc_count_d;
        lat_count_q  <= lat_count_d;
        lon_count_q  <= lon_count_d;
        date_q       <= date_d;
        date_count_q <= date_count_d;
        armed_q      <= armed_d;
        prev_q       <= prev_d;
        lat_deg_q    <= lat_deg_d;
        lat_len_q    <= lat_len_d;
        lat_hem_q    <= lat_hem_d;
        lon_deg_q    <= lon_deg_d;
        lon_len_q    <= lon_len_d;
        lon_hem_q    <= lon_hem_d;
        status_q     <= status_d;
        event_q      <= event_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stores that are only read after being written
  always_ff @(posedge clk_i) begin
    if (fire) begin
      tag_chars_q <= tag_chars_d;
      lat_dig_q   <= lat_dig_d;
      lon_dig_q   <= lon_dig_d;
    end
  end

  // Field registers hold the last request's result until the next one is taken
  assign out_valid_o = out_valid_q;
  assign out_user_o  = {event_q, status_q};
  assign out_data_o  = {5'b0,
                        3'(date_count_q),
                        date_q[0], date_q[1], date_q[2], date_q[3], date_q[4], date_q[5],
                        lon_hem_q, 4'(lon_len_q), lon_deg_q,
                        lat_hem_q, 4'(lat_len_q), lat_deg_q,
                        utc_q[0], utc_q[1], utc_q[2], utc_q[3], utc_q[4], utc_q[5]};

  `NRFE_ASSERT_NOW(a_status_no_event, out_valid_q && status_q, event_q == EV_NONE)
  `NRFE_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_q)
  `NRFE_ASSERT_NEXT(a_date_ends_sentence, fire && (event_d == EV_DATE), phase_q == PH_IDLE)
  `NRFE_ASSERT_NOW(a_tag_count_bound, tag_active_q, tag_count_q <= 3'(TAG_LEN))

endmodule

[hdl/nmea_rmc_field_extractor.sv]
// Top level of the NMEA RMC sentence field extractor
//
// Usage:
//  - s_axis carries one received character per request in tdata[7:0].
//  - m_axis returns one result per character: tuser holds the status bit
//    and the event code, tdata the captured and converted sentence fields.
//  - cfg_we_i writes the five-character sentence tag (first character in
//    the top byte); write it only while no character is in flight.
//  - Throughput: one character per cycle while m_axis_tready is high. The parser
//    updates all its state when it takes a character; a two-entry queue
//    between the classifier and the parser absorbs a stalled output.
//  - Path: an accepted character is first written to the queue; its result
//    is registered in the result register once the parser takes it.
//  - Reset: the tag returns to GPRMC, the parser goes idle and all counts,
//    degrees, hemisphere letters, UTC and date characters read zero.
//  - Stall: while m_axis_tready is low the result holds; up to two more
//    characters are accepted before s_axis_tready drops.
module nmea_rmc_field_extractor import nrfe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write
  input  logic                  cfg_we_i,
  input  logic [8*TAG_LEN-1:0]  cfg_wdata_i,
  // Character input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  // Result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [47:0] utc_text, [55:48] lat_degrees, [59:56] lat_digit_count,
  // [67:60] lat_hemisphere, [75:68] lon_degrees, [79:76] lon_digit_count,
  // [87:80] lon_hemisphere, [135:88] date_text, [138:136] date_char_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] status, [3:1] event_res
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic     item_valid;
  logic     item_ready;
  rx_item_t item;

  nrfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  nrfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser)
  );

endmodule
